/* rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Field widths, stage counts, limits and pipeline payload types.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefW  = 16;
  localparam int RootW  = 32;
  localparam int CountW = 2;
  localparam int DiscW  = 35;   // b*b - 4ac, signed
  localparam int RadW   = 50;   // d * 2^16, unsigned (d < 2^34)
  localparam int SqrtW  = 25;   // floor(sqrt(RadW value))
  localparam int NumW   = 27;   // -b*256 +/- s, signed
  localparam int DivNW  = 34;   // |n| * 128
  localparam int AbsAW  = 16;
  localparam int QuoW   = 34;

  localparam int SqrtStages = 5;  // 25 result bits, 5 per stage
  localparam int SqrtBitsPerStage = 5;
  localparam int DivStages = 6;   // 34 quotient bits, 6 per stage (last partial)
  localparam int DivBitsPerStage = 6;

  localparam logic [RootW-1:0] RootMax = 32'h7fff_ffff;
  localparam logic [RootW-1:0] RootMin = 32'h8000_0000;

  typedef struct packed {
    logic [CoefW-1:0] coef_a;
    logic [CoefW-1:0] coef_b;
    logic [CoefW-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [CountW-1:0] root_count;
    logic [RootW-1:0]  root_first;
    logic [RootW-1:0]  root_second;
    logic              degenerate;
    logic              saturated;
  } result_t;

  // item state through the square root stages
  typedef struct packed {
    logic                    degen;
    logic                    real_roots;
    logic                    single;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic [RadW-1:0]         rem;
    logic [SqrtW-1:0]        root;
  } sqrt_t;

  // one root division lane state
  typedef struct packed {
    logic             neg;
    logic [DivNW-1:0] num;   // shifts left as quotient bits come out
    logic [AbsAW:0]   rem;
    logic [QuoW-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic            degen;
    logic            real_roots;
    logic            single;
    logic [AbsAW-1:0] den;
    div_t            lo;
    div_t            hi;
  } divs_t;

endpackage

/* rtl/qrs_stream_if.sv */
// ----------------------------------------------------------------------------
// qrs_stream_if: valid/ready channel
// Carries one payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface qrs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/qrs_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_stage: one stage of the integer square root
// Resolves a fixed number of result bits of the digit-by-digit root.
// ----------------------------------------------------------------------------
module qrs_sqrt_stage #(
  parameter int FirstBit = 24
) (
  input  qrs_pkg::sqrt_t in_i,
  output qrs_pkg::sqrt_t out_o
);
  // restoring square root: root holds bits found so far, at their final weights
  always_comb begin
    logic [qrs_pkg::RadW+1:0] trial;
    logic [qrs_pkg::RadW+1:0] rem;
    logic [qrs_pkg::SqrtW-1:0] root;
    out_o = in_i;
    rem   = {2'b00, in_i.rem};
    root  = in_i.root;
    for (int k = 0; k < qrs_pkg::SqrtBitsPerStage; k++) begin
      if (FirstBit - k >= 0) begin
        // trial = (2*root + 2^j) * 2^j with j = bit position
        trial = ({{(qrs_pkg::RadW+2-qrs_pkg::SqrtW){1'b0}}, root}
                  << (FirstBit - k + 1)) +
                ({{(qrs_pkg::RadW+1){1'b0}}, 1'b1} << (2 * (FirstBit - k)));
        if (rem >= trial) begin
          rem  = rem - trial;
          root = root | (qrs_pkg::SqrtW'(1) << (FirstBit - k));
        end
      end
    end
    out_o.rem  = rem[qrs_pkg::RadW-1:0];
    out_o.root = root;
  end
endmodule

/* rtl/qrs_div_stage.sv */
// ----------------------------------------------------------------------------
// qrs_div_stage: one stage of the unsigned restoring divider
// Produces a few quotient bits for both root lanes.
// ----------------------------------------------------------------------------
module qrs_div_stage #(
  parameter int Steps = 6
) (
  input  qrs_pkg::divs_t in_i,
  output qrs_pkg::divs_t out_o
);
  function automatic qrs_pkg::div_t lane(qrs_pkg::div_t d, logic [qrs_pkg::AbsAW-1:0] den);
    logic [qrs_pkg::AbsAW+1:0] t;
    qrs_pkg::div_t r;
    r = d;
    for (int k = 0; k < Steps; k++) begin
      t = {r.rem, r.num[qrs_pkg::DivNW-1]};
      r.num = {r.num[qrs_pkg::DivNW-2:0], 1'b0};
      if (t >= {2'b00, den}) begin
        t = t - {2'b00, den};
        r.quo = {r.quo[qrs_pkg::QuoW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[qrs_pkg::QuoW-2:0], 1'b0};
      end
      r.rem = t[qrs_pkg::AbsAW:0];
    end
    return r;
  endfunction

  always_comb begin
    out_o    = in_i;
    out_o.lo = lane(in_i.lo, in_i.den);
    out_o.hi = lane(in_i.hi, in_i.den);
  end
endmodule

/* rtl/quadratic_root_solver.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c
// Pipelined fixed-point solver, Q8.8 coefficients in, Q16.16 roots out.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one request = {coef_a, coef_b, coef_c}, signed Q8.8.
//   out_if : one result per request = {root_count, root_first, root_second,
//            degenerate, saturated}; roots signed Q16.16.
//   Stages: 1 discriminant products, 1 discriminant sum, 5 square root
//   (5 bits each), 1 numerator, 6 division (6 bits, 4 in the last), 1 sign/clamp.
//   Throughput is one request per cycle; every stage holds a valid bit.
//   When out_if.ready is low and the output holds a result, the whole
//   pipeline holds (global enable); in_if.ready follows out_if.ready or
//   an empty output slot, so a bubble in the output is filled while the
//   receiver stalls and nothing is lost or repeated.
//   Reset clears all valid bits; no item is in flight after reset.
//   a == 0 gives degenerate with no roots; d < 0 gives no roots.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  logic clk_i,
  input  logic rst_ni,
  qrs_stream_if.sink   in_if,
  qrs_stream_if.source out_if
);
  localparam int NStg = 15;

  logic [NStg-1:0] vld_q;
  logic            adv;
  // pipeline moves unless the last stage is full and stalled
  assign adv = !vld_q[NStg-1] || out_if.ready;
  assign in_if.ready = adv;

  // ---- stage 0: products
  qrs_pkg::coef_t cin;
  assign cin = in_if.data;
  logic signed [31:0] bb_q, ac_q;
  logic signed [15:0] a0_q, b0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb_q <= $signed(cin.coef_b) * $signed(cin.coef_b);
      ac_q <= $signed(cin.coef_a) * $signed(cin.coef_c);
      a0_q <= $signed(cin.coef_a);
      b0_q <= $signed(cin.coef_b);
    end
  end

  // ---- stage 1: discriminant and classification
  logic signed [qrs_pkg::DiscW-1:0] disc;
  assign disc = qrs_pkg::DiscW'(bb_q) - (qrs_pkg::DiscW'(ac_q) <<< 2);
  qrs_pkg::sqrt_t sq_q [qrs_pkg::SqrtStages+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].degen      <= (a0_q == '0);
      sq_q[0].real_roots <= (a0_q != '0) && !disc[qrs_pkg::DiscW-1];
      sq_q[0].single     <= (disc == '0);
      sq_q[0].a          <= a0_q;
      sq_q[0].b          <= b0_q;
      sq_q[0].rem        <= disc[qrs_pkg::DiscW-1] ? '0 :
                            {disc[qrs_pkg::DiscW-2:0], 16'h0000};
      sq_q[0].root       <= '0;
    end
  end

  // ---- stages 2..6: square root
  for (genvar g = 0; g < qrs_pkg::SqrtStages; g++) begin : g_sqrt
    qrs_pkg::sqrt_t nx;
    qrs_sqrt_stage #(
      .FirstBit(qrs_pkg::SqrtW - 1 - g * qrs_pkg::SqrtBitsPerStage)
    ) u_stage (.in_i(sq_q[g]), .out_o(nx));
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[g+1] <= nx;
    end
  end

  // ---- stage 7: numerators, magnitudes
  qrs_pkg::sqrt_t sf;
  assign sf = sq_q[qrs_pkg::SqrtStages];
  logic signed [qrs_pkg::NumW-1:0] nb, n1, n2;
  logic [qrs_pkg::NumW-1:0] m1, m2;
  logic [qrs_pkg::AbsAW-1:0] aabs;
  always_comb begin
    nb   = -(qrs_pkg::NumW'(sf.b) <<< 8);
    n1   = nb - $signed({2'b00, sf.root});
    n2   = nb + $signed({2'b00, sf.root});
    m1   = n1[qrs_pkg::NumW-1] ? -n1 : n1;
    m2   = n2[qrs_pkg::NumW-1] ? -n2 : n2;
    aabs = sf.a[qrs_pkg::CoefW-1] ? 16'(-sf.a) : 16'(sf.a);
  end
  qrs_pkg::divs_t dv_q [qrs_pkg::DivStages+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].degen      <= sf.degen;
      dv_q[0].real_roots <= sf.real_roots;
      dv_q[0].single     <= sf.single;
      dv_q[0].den        <= aabs;
      dv_q[0].lo.neg     <= n1[qrs_pkg::NumW-1] ^ sf.a[qrs_pkg::CoefW-1];
      dv_q[0].lo.num     <= {m1, 7'b0};
      dv_q[0].lo.rem     <= '0;
      dv_q[0].lo.quo     <= '0;
      dv_q[0].hi.neg     <= n2[qrs_pkg::NumW-1] ^ sf.a[qrs_pkg::CoefW-1];
      dv_q[0].hi.num     <= {m2, 7'b0};
      dv_q[0].hi.rem     <= '0;
      dv_q[0].hi.quo     <= '0;
    end
  end

  // ---- stages 8..13: division, 34 quotient bits
  for (genvar g = 0; g < qrs_pkg::DivStages; g++) begin : g_div
    localparam int Steps = (g == qrs_pkg::DivStages - 1) ?
      qrs_pkg::QuoW - g * qrs_pkg::DivBitsPerStage : qrs_pkg::DivBitsPerStage;
    qrs_pkg::divs_t nx;
    qrs_div_stage #(.Steps(Steps)) u_stage (.in_i(dv_q[g]), .out_o(nx));
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[g+1] <= nx;
    end
  end

  // ---- stage 14: sign, clamp, output register
  qrs_pkg::divs_t df;
  assign df = dv_q[qrs_pkg::DivStages];

  function automatic logic [32:0] fix(logic neg, logic [qrs_pkg::QuoW-1:0] q);
    // returns {sat, value}
    if (!neg) begin
      if (q > 34'h07fff_ffff) return {1'b1, qrs_pkg::RootMax};
      return {1'b0, q[31:0]};
    end else begin
      if (q > 34'h080000000) return {1'b1, qrs_pkg::RootMin};
      return {1'b0, 32'(-q)};
    end
  endfunction

  logic [32:0] f1, f2;
  assign f1 = fix(df.lo.neg, df.lo.quo);
  assign f2 = fix(df.hi.neg, df.hi.quo);
  qrs_pkg::result_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.degenerate  <= df.degen;
      res_q.root_count  <= !df.real_roots ? 2'd0 : (df.single ? 2'd1 : 2'd2);
      res_q.root_first  <= df.real_roots ? f1[31:0] : '0;
      res_q.root_second <= df.real_roots ? f2[31:0] : '0;
      res_q.saturated   <= df.real_roots && (f1[32] || f2[32]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_if.valid};
    end
  end

  assign out_if.valid = vld_q[NStg-1];
  assign out_if.data  = res_q;

  // ---- assertions
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(vld_q))
    else $error("pipeline moved during stall");
  a_degen_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.degenerate |-> out_if.data.root_count == 2'd0)
    else $error("degenerate with roots");
  a_single_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.root_count == 2'd1 |->
      out_if.data.root_first == out_if.data.root_second)
    else $error("single root differs");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("not ready with empty output");
endmodule

/* sim/tb_quadratic_root_solver.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver: self-checking bench for the quadratic root solver
// Drives coefficient requests with bursty timing, stalls the result side on
// its own pattern, and compares every result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;

  localparam int Latency   = 15;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qrs_stream_if #(.T(qrs_pkg::coef_t))   in_if ();
  qrs_stream_if #(.T(qrs_pkg::result_t)) out_if ();

  quadratic_root_solver i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  qrs_pkg::coef_t   coef_pending_q[$];   // requests waiting for the driver
  qrs_pkg::result_t roots_expected_q[$]; // predicted results, oldest first
  int      errors = 0;
  int      cycles = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;      // driver pauses while set
  bit      in_taken_q = 1'b0;    // request accepted at the last rising edge

  // Integer square root, truncated.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [qrs_pkg::RootW-1:0] clamp_root(longint q, inout logic sat);
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return qrs_pkg::RootMax;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return qrs_pkg::RootMin;
    end
    return q[qrs_pkg::RootW-1:0];
  endfunction

  // Predicts the solver result for one coefficient set.
  function automatic qrs_pkg::result_t solve_roots(qrs_pkg::coef_t co);
    qrs_pkg::result_t r;
    longint a, b, c, d, s, nb;
    logic    sat;
    a = longint'($signed(co.coef_a));
    b = longint'($signed(co.coef_b));
    c = longint'($signed(co.coef_c));
    r = '0;
    sat = 1'b0;
    if (a == 0) begin
      r.degenerate = 1'b1;
    end else begin
      d = b * b - 4 * a * c;
      if (d >= 0) begin
        s  = longint'(int_sqrt(longint'(d) * 65536));
        nb = -b * 256;
        // SV division truncates toward zero, like the hardware divider
        r.root_first  = clamp_root(((nb - s) * 128) / a, sat);
        r.root_second = clamp_root(((nb + s) * 128) / a, sat);
        r.root_count  = (d == 0) ? 2'd1 : 2'd2;
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return 16'(int'($urandom_range(0, 8)) - 4);   // near zero
      1:       return 16'(int'($urandom_range(0, 1024)) - 512);
      2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    qrs_pkg::coef_t co;
    co.coef_a = a;
    co.coef_b = b;
    co.coef_c = c;
    coef_pending_q.push_back(co);
  endtask

  // Handshake seen at the rising edge, before the pipeline moves.
  always @(posedge clk_i) begin
    in_taken_q <= rst_ni && in_if.valid && in_if.ready;
  end

  // Driver: bursts of random length with random gaps, changes at negedge.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      // retire the request that was accepted at the last rising edge
      if (in_taken_q) begin
        roots_expected_q.push_back(solve_roots(in_if.data));
        void'(coef_pending_q.pop_front());
      end
      if (in_if.valid && !in_taken_q) begin
        // hold the request until it is taken
      end else if (gap_left > 0 || hold_off || coef_pending_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
          gap_left = $urandom_range(1, 12);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= coef_pending_q[0];
      end
    end
  end

  // Result side stall pattern: phases of always-ready, random and long stalls.
  int stall_phase = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (cycles % 97 == 0) stall_phase = $urandom_range(0, 2);
      case (stall_phase)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((cycles % 16) < 3);
      endcase
    end
  end

  // Monitor: sample at the rising edge, compare field by field.
  always @(posedge clk_i) begin
    qrs_pkg::result_t got, exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (roots_expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp = roots_expected_q.pop_front();
        if (got.root_count !== exp.root_count) begin
          $display("%0t: root_count exp %0d got %0d", $time, exp.root_count,
                   got.root_count);
          errors++;
        end
        if (got.root_first !== exp.root_first) begin
          $display("%0t: root_first exp %h got %h", $time, exp.root_first,
                   got.root_first);
          errors++;
        end
        if (got.root_second !== exp.root_second) begin
          $display("%0t: root_second exp %h got %h", $time, exp.root_second,
                   got.root_second);
          errors++;
        end
        if (got.degenerate !== exp.degenerate) begin
          $display("%0t: degenerate exp %b got %b", $time, exp.degenerate,
                   got.degenerate);
          errors++;
        end
        if (got.saturated !== exp.saturated) begin
          $display("%0t: saturated exp %b got %b", $time, exp.saturated,
                   got.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_quadratic_root_solver NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;

    // Directed: degenerate, negative/zero/positive discriminant, extremes.
    add_req(16'h0000, 16'h0100, 16'h0100);   // a zero
    add_req(16'h0000, 16'h0000, 16'h0000);
    add_req(16'h0100, 16'h0000, 16'h0100);   // x^2 + 1, no real roots
    add_req(16'h0100, 16'hfe00, 16'h0100);   // (x-1)^2, single root
    add_req(16'h0100, 16'h0000, 16'hff00);   // x^2 - 1, two roots
    add_req(16'h0100, 16'h0300, 16'h0200);   // x^2+3x+2
    add_req(16'hff00, 16'h0100, 16'h0600);   // negative a
    add_req(16'h0001, 16'h7fff, 16'h0000);   // tiny a, large negative root
    add_req(16'h0001, 16'h8000, 16'h8000);
    add_req(16'hffff, 16'h8000, 16'h7fff);
    add_req(16'h7fff, 16'h7fff, 16'h7fff);
    add_req(16'h8000, 16'h8000, 16'h8000);
    add_req(16'h8000, 16'h7fff, 16'h7fff);
    add_req(16'h7fff, 16'h8000, 16'h8000);
    add_req(16'h0001, 16'h0000, 16'h8000);   // roots of equal size and opposite sign
    add_req(16'h0001, 16'h0002, 16'h0001);   // single root tiny a
    add_req(16'h8000, 16'h0000, 16'h0000);   // single root at zero, d == 0
    add_req(16'h5555, 16'haaaa, 16'h5555);
    add_req(16'haaaa, 16'h5555, 16'haaaa);
    add_req(16'hffff, 16'hffff, 16'hffff);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Random part, with one full drain midway.
    for (n = 0; n < 1100; n++) begin
      if (n == 500) begin
        wait (coef_pending_q.size() == 0);
        hold_off = 1'b1;
        wait (roots_expected_q.size() == 0);
        @(negedge clk_i);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 4))
        0: begin
          // single root: b^2 = 4ac with b = 2k, a*c = k^2 via a = k, c = k
          int k;
          k = int'($urandom_range(0, 180)) - 90;
          add_req(16'(k), 16'(2 * k), 16'(k));
        end
        1: add_req(16'($urandom_range(0, 1) ? 0 : $urandom), 16'($urandom),
                   16'($urandom));
        default: add_req(rand_coef(), rand_coef(), rand_coef());
      endcase
      if (coef_pending_q.size() > 64) wait (coef_pending_q.size() < 16);
    end

    wait (coef_pending_q.size() == 0);
    wait (roots_expected_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_quadratic_root_solver OK");
    end else begin
      $display("tb_quadratic_root_solver NOT OK");
    end
    $finish;
  end
endmodule
